/* hw/rtl/rau_pkg.sv */
// ---------------------------------------------------------------------------
// rau_pkg: shared types for the rational arithmetic unit
// opcodes, status codes, state encodings and the entry passed from front to back
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package rau_pkg;

  typedef enum logic [2:0] {
    OP_ADD  = 3'd0,
    OP_SUB  = 3'd1,
    OP_MUL  = 3'd2,
    OP_DIV  = 3'd3,
    OP_CMP  = 3'd4,
    OP_NORM = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    ERR_OK       = 2'd0,
    ERR_ZERO_DEN = 2'd1,
    ERR_DIV_ZERO = 2'd2
  } err_e;

  typedef enum logic [1:0] {
    ORD_LT = 2'd0,
    ORD_EQ = 2'd1,
    ORD_GT = 2'd2
  } ord_e;

  typedef enum logic [1:0] {F_IDLE, F_MUL, F_PUSH} fstate_e;

  typedef enum logic [2:0] {B_IDLE, B_SETUP, B_GCD, B_DIVN, B_DIVD, B_DONE} bstate_e;

  typedef struct packed {
    logic signed [63:0] n;
    logic signed [63:0] d;
    ord_e               ord;
    err_e               err;
  } qent_t;

endpackage

/* hw/rtl/rau_queue.sv */
// ---------------------------------------------------------------------------
// rau_queue: two-entry queue between front and back
// lets the front classify the next request while the back reduces
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module rau_queue
  import rau_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  qent_t push_data_i,
  output logic  full_o,
  input  logic  pop_i,
  output qent_t pop_data_o,
  output logic  empty_o
);

  qent_t       mem_q [2];
  logic        wptr_q, rptr_q;
  logic [1:0]  cnt_q;

  assign full_o     = cnt_q[1];
  assign empty_o    = (cnt_q == 2'd0);
  assign pop_data_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push_i) wptr_q <= ~wptr_q;
      if (pop_i)  rptr_q <= ~rptr_q;
      if (push_i && !pop_i)      cnt_q <= cnt_q + 2'd1;
      else if (!push_i && pop_i) cnt_q <= cnt_q - 2'd1;
    end
  end

endmodule

/* hw/rtl/rau_front.sv */
// ---------------------------------------------------------------------------
// rau_front: request intake and cross products
// saturates operands, checks denominators, forms n and d with one multiplier
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module rau_front
  import rau_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  logic [2:0]   opcode_i,
  input  logic [31:0]  a_num_i,
  input  logic [31:0]  a_den_i,
  input  logic [31:0]  b_num_i,
  input  logic [31:0]  b_den_i,
  output logic         push_o,
  output qent_t        push_data_o,
  input  logic         full_i
);

  fstate_e            state_q, state_d;
  logic [1:0]         cnt_q, cnt_d;
  op_e                op_q;
  err_e               err_q;
  logic signed [31:0] an_q, ad_q, bn_q, bd_q;
  logic signed [63:0] p_q [4];

  function automatic logic [31:0] sat32(logic [31:0] v);
    return (v == 32'h8000_0000) ? 32'h8000_0001 : v;
  endfunction

  function automatic logic [30:0] mag31(logic signed [31:0] v);
    logic [31:0] t;
    t = v[31] ? -v : v;
    return t[30:0];
  endfunction

  logic [31:0] an_s, ad_s, bn_s, bd_s;
  assign an_s = sat32(a_num_i);
  assign ad_s = sat32(a_den_i);
  assign bn_s = sat32(b_num_i);
  assign bd_s = sat32(b_den_i);

  logic               accept;
  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == F_IDLE);

  // operand select for the shared multiplier
  logic signed [31:0] x_sel, y_sel;
  logic [61:0]        prod;
  logic [63:0]        prod_x;
  logic               neg;

  always_comb begin
    case (cnt_q)
      2'd0:    begin x_sel = an_q; y_sel = bd_q; end
      2'd1:    begin x_sel = ad_q; y_sel = bn_q; end
      2'd2:    begin x_sel = ad_q; y_sel = bd_q; end
      default: begin x_sel = an_q; y_sel = bn_q; end
    endcase
  end

  assign neg    = x_sel[31] ^ y_sel[31];
  assign prod   = mag31(x_sel) * mag31(y_sel);
  assign prod_x = {2'b00, prod};

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q <= (opcode_i > OP_NORM) ? OP_NORM : op_e'(opcode_i);
      an_q <= an_s;
      ad_q <= ad_s;
      bn_q <= bn_s;
      bd_q <= bd_s;
      if (opcode_i >= OP_NORM) err_q <= (ad_s == 32'd0) ? ERR_ZERO_DEN : ERR_OK;
      else err_q <= (ad_s == 32'd0 || bd_s == 32'd0) ? ERR_ZERO_DEN : ERR_OK;
    end
    if (state_q == F_MUL) begin
      p_q[cnt_q] <= neg ? -prod_x : prod_x;
    end
  end

  // combine products into the entry
  logic signed [63:0] diff, sum;
  always_comb begin
    diff        = p_q[0] - p_q[1];
    sum         = p_q[0] + p_q[1];
    push_data_o = '0;
    case (op_q)
      OP_ADD:  begin push_data_o.n = sum;    push_data_o.d = p_q[2]; end
      OP_SUB,
      OP_CMP:  begin push_data_o.n = diff;   push_data_o.d = p_q[2]; end
      OP_MUL:  begin push_data_o.n = p_q[3]; push_data_o.d = p_q[2]; end
      OP_DIV:  begin push_data_o.n = p_q[0]; push_data_o.d = p_q[1]; end
      default: begin
        push_data_o.n = {{32{an_q[31]}}, an_q};
        push_data_o.d = {{32{ad_q[31]}}, ad_q};
      end
    endcase
    if (err_q != ERR_OK || op_q == OP_NORM) push_data_o.ord = ORD_LT;
    else if (diff == 64'sd0)                push_data_o.ord = ORD_EQ;
    else if (!diff[63] ^ p_q[2][63])        push_data_o.ord = ORD_GT;
    else                                    push_data_o.ord = ORD_LT;
    if (err_q != ERR_OK)                           push_data_o.err = err_q;
    else if (op_q == OP_DIV && p_q[1] == 64'sd0)   push_data_o.err = ERR_DIV_ZERO;
    else                                           push_data_o.err = ERR_OK;
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    push_o  = 1'b0;
    case (state_q)
      F_IDLE: begin
        if (accept) begin
          state_d = F_MUL;
          cnt_d   = 2'd0;
        end
      end
      F_MUL: begin
        cnt_d = cnt_q + 2'd1;
        if (cnt_q == 2'd3) state_d = F_PUSH;
      end
      F_PUSH: begin
        if (!full_i) begin
          push_o  = 1'b1;
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      cnt_q   <= 2'd0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

/* hw/rtl/rau_back.sv */
// ---------------------------------------------------------------------------
// rau_back: fraction reduction
// binary gcd, then one shared restoring divider for numerator and denominator
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module rau_back
  import rau_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          empty_i,
  input  qent_t         pop_data_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [63:0]   result_num_o,
  output logic [62:0]   result_den_o,
  output logic          is_whole_o,
  output logic [1:0]    order_o,
  output logic [1:0]    error_code_o
);

  bstate_e            state_q, state_d;
  qent_t              ent_q;
  logic               neg_q;
  logic [62:0]        mag_q, den_q, u_q, v_q, g_q, x_q, r_q;
  logic [5:0]         k_q, cnt_q;
  logic               out_valid_q;

  logic signed [63:0] nn, dabs;
  logic [63:0]        nmag;
  logic [63:0]        rs;
  logic               qbit;
  logic [62:0]        x_next, r_next;
  logic               load_out;

  assign nn   = ent_q.d[63] ? -ent_q.n : ent_q.n;
  assign dabs = ent_q.d[63] ? -ent_q.d : ent_q.d;
  assign nmag = nn[63] ? -nn : nn;

  // one divider step
  assign rs     = {r_q, x_q[62]};
  assign qbit   = (rs >= {1'b0, g_q});
  assign r_next = qbit ? 63'(rs - {1'b0, g_q}) : rs[62:0];
  assign x_next = {x_q[61:0], qbit};

  always_comb begin
    state_d  = state_q;
    pop_o    = 1'b0;
    load_out = 1'b0;
    case (state_q)
      B_IDLE: begin
        if (!empty_i) begin
          pop_o   = 1'b1;
          state_d = B_SETUP;
        end
      end
      B_SETUP: begin
        if (ent_q.err != ERR_OK || nn == 64'sd0) state_d = B_DONE;
        else                                     state_d = B_GCD;
      end
      B_GCD:   if (u_q == v_q) state_d = B_DIVN;
      B_DIVN:  if (cnt_q == 6'd62) state_d = B_DIVD;
      B_DIVD:  if (cnt_q == 6'd62) state_d = B_DONE;
      B_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          load_out = 1'b1;
          state_d  = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) ent_q <= pop_data_i;
    case (state_q)
      B_SETUP: begin
        neg_q <= nn[63];
        if (ent_q.err != ERR_OK) begin
          mag_q <= '0;
          den_q <= '0;
        end else if (nn == 64'sd0) begin
          mag_q <= '0;
          den_q <= 63'd1;
        end else begin
          mag_q <= nmag[62:0];
          den_q <= dabs[62:0];
          u_q   <= nmag[62:0];
          v_q   <= dabs[62:0];
          k_q   <= '0;
        end
      end
      B_GCD: begin
        if (u_q == v_q) begin
          g_q   <= u_q << k_q;
          x_q   <= mag_q;
          r_q   <= '0;
          cnt_q <= '0;
        end else if (!u_q[0] && !v_q[0]) begin
          u_q <= u_q >> 1;
          v_q <= v_q >> 1;
          k_q <= k_q + 6'd1;
        end else if (!u_q[0]) begin
          u_q <= u_q >> 1;
        end else if (!v_q[0]) begin
          v_q <= v_q >> 1;
        end else if (u_q > v_q) begin
          u_q <= u_q - v_q;
        end else begin
          v_q <= v_q - u_q;
        end
      end
      B_DIVN: begin
        if (cnt_q == 6'd62) begin
          mag_q <= x_next;
          x_q   <= den_q;
          r_q   <= '0;
          cnt_q <= '0;
        end else begin
          x_q   <= x_next;
          r_q   <= r_next;
          cnt_q <= cnt_q + 6'd1;
        end
      end
      B_DIVD: begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd62) begin
          den_q <= x_next;
        end else begin
          x_q <= x_next;
          r_q <= r_next;
        end
      end
      default: ;
    endcase
    if (load_out) begin
      result_num_o <= neg_q ? -{1'b0, mag_q} : {1'b0, mag_q};
      result_den_o <= den_q;
      is_whole_o   <= (ent_q.err == ERR_OK) && (den_q == 63'd1);
      order_o      <= ent_q.ord;
      error_code_o <= ent_q.err;
    end
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out)         out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

endmodule

/* hw/rtl/rational_arithmetic_unit.sv */
// ---------------------------------------------------------------------------
// rational_arithmetic_unit: exact fraction arithmetic with gcd reduction
// add, subtract, multiply, divide, compare or normalize two fractions
// ---------------------------------------------------------------------------
// one request on the s_axis channel gives one result on the m_axis channel,
// in order. the opcode rides in s_axis_tuser, the four operands in tdata.
// the front takes a request, forms the cross products in turn on one
// 31x31 multiplier, then places the entry in a two-entry queue; it
// takes the next request while the back is still busy.
// the back reduces: binary gcd, then two divisions by the gcd on one
// shared divider, first the numerator, then the denominator; a zero
// numerator or an error skips both. the back reduces one entry at a
// time, and the sustained rate is that of the back.
// the result sits in an output register; while the receiver stalls the
// back holds its finished result and the queue fills, then s_axis_tready
// drops. reset empties the queue and the output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module rational_arithmetic_unit
  import rau_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,   // a_num, a_den, b_num, b_den
  input  logic [2:0]   s_axis_tuser,   // opcode
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [135:0] m_axis_tdata    // result_num, result_den, is_whole, order,
                                       // error_code, zero pad
);

  logic  push, full, pop, empty;
  qent_t push_data, pop_data;
  logic [63:0] result_num;
  logic [62:0] result_den;
  logic        is_whole;
  logic [1:0]  order, error_code;

  rau_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .opcode_i    (s_axis_tuser),
    .a_num_i     (s_axis_tdata[31:0]),
    .a_den_i     (s_axis_tdata[63:32]),
    .b_num_i     (s_axis_tdata[95:64]),
    .b_den_i     (s_axis_tdata[127:96]),
    .push_o      (push),
    .push_data_o (push_data),
    .full_i      (full)
  );

  rau_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .empty_o     (empty)
  );

  rau_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .empty_i      (empty),
    .pop_data_i   (pop_data),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .result_num_o (result_num),
    .result_den_o (result_den),
    .is_whole_o   (is_whole),
    .order_o      (order),
    .error_code_o (error_code)
  );

  assign m_axis_tdata = {4'b0000, error_code, order, is_whole, result_den, result_num};

endmodule

/* tb/sv/rational_arithmetic_unit_tb.sv */
// ---------------------------------------------------------------------------
// rational_arithmetic_unit_tb: self-checking bench for the fraction unit
// drives operand pairs with opcodes, predicts the reduced fraction, order
// and status for each request, and checks every result in order
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module rational_arithmetic_unit_tb
  import rau_pkg::*;
;

  typedef struct packed {
    logic signed [63:0] num;
    logic [62:0]        den;
    logic               whole;
    logic [1:0]         ord;
    logic [1:0]         err;
  } frac_res_t;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata;
  logic [2:0]   s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [135:0] m_axis_tdata;

  frac_res_t    frac_expq[$];
  int           mismatches = 0;
  int           cycles = 0;
  bit           calm;

  localparam int CYCLE_LIMIT = 2000000;
  localparam logic [31:0] MOST_NEG = 32'h8000_0000;
  localparam logic [31:0] MOST_POS = 32'h7FFF_FFFF;

  rational_arithmetic_unit dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic logic signed [63:0] clamp31(logic [31:0] raw);
    logic signed [63:0] v;
    v = $signed(raw);
    if (v < -64'sd2147483647) v = -64'sd2147483647;
    return v;
  endfunction

  function automatic frac_res_t reduce_frac(logic signed [63:0] n, logic signed [63:0] d);
    frac_res_t r;
    logic [63:0] mag, dm, x, y, t;
    logic neg;
    r = '0;
    if (d < 0) begin
      n = -n;
      d = -d;
    end
    if (n == 0) begin
      r.den = 63'd1;
      r.whole = 1'b1;
      return r;
    end
    neg = n < 0;
    mag = neg ? -n : n;
    dm = d;
    x = mag;
    y = dm;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    mag = mag / x;
    dm = dm / x;
    r.num = neg ? -$signed(mag) : $signed(mag);
    r.den = dm[62:0];
    r.whole = (dm == 64'd1);
    return r;
  endfunction

  function automatic frac_res_t predict_frac(logic [2:0] opc, logic [127:0] ops);
    frac_res_t r;
    logic signed [63:0] an, ad, bn, bd, diff, dd, n, d;
    int s;
    r = '0;
    an = clamp31(ops[31:0]);
    ad = clamp31(ops[63:32]);
    bn = clamp31(ops[95:64]);
    bd = clamp31(ops[127:96]);
    if (opc > OP_NORM) opc = OP_NORM;
    if (opc == OP_NORM) begin
      if (ad == 0) r.err = ERR_ZERO_DEN;
      else r = reduce_frac(an, ad);
      return r;
    end
    if (ad == 0 || bd == 0) begin
      r.err = ERR_ZERO_DEN;
      return r;
    end
    diff = an * bd - ad * bn;
    dd = ad * bd;
    s = (diff > 0) ? 1 : (diff < 0) ? -1 : 0;
    if (dd < 0) s = -s;
    d = dd;
    case (opc)
      OP_ADD: n = an * bd + ad * bn;
      OP_MUL: n = an * bn;
      OP_DIV: begin
        n = an * bd;
        d = ad * bn;
      end
      default: n = diff;
    endcase
    if (d == 0) r.err = ERR_DIV_ZERO;
    else r = reduce_frac(n, d);
    r.ord = 2'(s + 1);
    return r;
  endfunction

  task automatic send_frac_op(logic [2:0] opc, logic [31:0] an, logic [31:0] ad,
                              logic [31:0] bn, logic [31:0] bd);
    logic [127:0] ops;
    ops = {bd, bn, ad, an};
    while (!calm && $urandom_range(99) < 28) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= ops;
    s_axis_tuser  <= opc;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    frac_expq.push_back(predict_frac(opc, ops));
  endtask

  always @(posedge clk_i) begin
    frac_res_t got, want;
    cycles <= cycles + 1;
    if (!rst_ni) m_axis_tready <= 1'b0;
    else m_axis_tready <= calm || ($urandom_range(99) >= 28);
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tdata[63:0], m_axis_tdata[126:64], m_axis_tdata[127],
             m_axis_tdata[129:128], m_axis_tdata[131:130]};
      if (frac_expq.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", m_axis_tdata);
      end else begin
        want = frac_expq.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp num %0d den %0d w %0b o %0d e %0d,",
                     want.num, want.den, want.whole, want.ord, want.err,
                     " got num %0d den %0d w %0b o %0d e %0d",
                     got.num, got.den, got.whole, got.ord, got.err);
        end
      end
    end
  end

  function automatic logic [31:0] rand_val();
    case ($urandom_range(5))
      0: return $urandom_range(20) - 10;
      1: return MOST_NEG;
      2: return $urandom_range(1) ? MOST_POS : -MOST_POS;
      3: return $urandom_range(1000) - 500;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] rand_den();
    logic [31:0] v;
    v = rand_val();
    if (v == 0 && $urandom_range(9) != 0) v = 32'd3;
    return v;
  endfunction

  task automatic test_directed();
    send_frac_op(OP_ADD, 1, 2, 1, 3);
    send_frac_op(OP_SUB, 1, 2, 1, 2);
    send_frac_op(OP_MUL, -4, 6, 3, -8);
    send_frac_op(OP_DIV, 2, 3, 4, 9);
    send_frac_op(OP_CMP, 1, 3, 1, 2);
    send_frac_op(OP_CMP, 5, -1, 4, 1);
    send_frac_op(OP_NORM, 12, -18, 0, 0);
    send_frac_op(3'd6, 7, 14, 1, 1);
    send_frac_op(3'd7, 0, 0, 5, 5);
    send_frac_op(OP_ADD, 1, 0, 1, 1);
    send_frac_op(OP_DIV, 1, 1, 1, 0);
    send_frac_op(OP_DIV, 3, 4, 0, 7);
    send_frac_op(OP_MUL, 0, 5, 9, 7);
    send_frac_op(OP_ADD, MOST_NEG, MOST_POS, MOST_NEG, MOST_NEG);
    send_frac_op(OP_MUL, MOST_POS, 1, MOST_POS, 1);
    send_frac_op(OP_SUB, MOST_POS, MOST_NEG, MOST_POS, 3);
    send_frac_op(OP_DIV, -MOST_POS, 2, MOST_POS, -1);
    send_frac_op(OP_NORM, MOST_NEG, MOST_NEG, 1, 1);
    send_frac_op(OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
  endtask

  task automatic test_random(int count);
    for (int i = 0; i < count; i++) begin
      calm = (i >= count / 3) && (i < count / 2);
      send_frac_op(3'($urandom_range(7)), rand_val(), rand_den(), rand_val(), rand_den());
    end
    calm = 1'b0;
  endtask

  initial begin
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    calm          = 1'b0;
    rst_ni        = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(730);
    s_axis_tvalid <= 1'b0;
    while (frac_expq.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (mismatches == 0) $display("rational_arithmetic_unit_tb: clean");
    else $display("rational_arithmetic_unit_tb: errors");
    $finish;
  end

  initial begin
    wait (cycles >= CYCLE_LIMIT);
    $display("rational_arithmetic_unit_tb: errors");
    $finish;
  end

endmodule
